/* rtl/belt_block_encrypt_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the block encryption core
// Clocked implication checks that vanish when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef BELT_BLOCK_ENCRYPT_CORE_ASSERT_SVH
`define BELT_BLOCK_ENCRYPT_CORE_ASSERT_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define BELT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define BELT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BELT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BELT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/belt_pkg.sv */
// ---------------------------------------------------------------------------
// Block encryption package
// Round types, the H substitution box and the G transform.
// ---------------------------------------------------------------------------
package belt_pkg;

	typedef logic [31:0] word_t;

	// Four state words of a block moving through the rounds.
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} blk_t;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_KEY_01 = 3'd0;
	localparam logic [2:0] REG_KEY_23 = 3'd1;
	localparam logic [2:0] REG_KEY_45 = 3'd2;
	localparam logic [2:0] REG_KEY_67 = 3'd3;
	localparam logic [2:0] REG_KEY_SIZE = 3'd4;

	// Key size codes.
	localparam logic [1:0] KSIZE_128 = 2'd0;
	localparam logic [1:0] KSIZE_192 = 2'd1;

	// H substitution box.
	function automatic logic [7:0] sbox_h(input logic [7:0] x);
		logic [7:0] tbl [256];
		tbl = '{
		8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
		8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
		8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
		8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
		8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
		8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
		8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
		8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
		8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
		8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
		8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
		8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
		8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
		8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
		8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
		8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D};
		return tbl[x];
	endfunction

	// G transform: byte substitution, then rotate left by r.
	function automatic word_t g_fn(input word_t x, input logic [4:0] r);
		word_t y;
		y = {sbox_h(x[31:24]), sbox_h(x[23:16]), sbox_h(x[15:8]), sbox_h(x[7:0])};
		return (y << r) | (y >> (6'd32 - {1'b0, r}));
	endfunction

endpackage

/* rtl/belt_keysched.sv */
// ---------------------------------------------------------------------------
// Key registers and expansion
// Holds the configuration registers and produces the eight expanded words.
// ---------------------------------------------------------------------------
module belt_keysched (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output belt_pkg::word_t     ek [8]
);

	logic [63:0] key01_q, key23_q, key45_q, key67_q;
	logic [1:0]  ksize_q;
	belt_pkg::word_t k [8];

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q <= '0;
			key23_q <= '0;
			key45_q <= '0;
			key67_q <= '0;
			ksize_q <= 2'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				belt_pkg::REG_KEY_01: key01_q <= cfg_data;
				belt_pkg::REG_KEY_23: key23_q <= cfg_data;
				belt_pkg::REG_KEY_45: key45_q <= cfg_data;
				belt_pkg::REG_KEY_67: key67_q <= cfg_data;
				belt_pkg::REG_KEY_SIZE: ksize_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign k[0] = key01_q[31:0];
	assign k[1] = key01_q[63:32];
	assign k[2] = key23_q[31:0];
	assign k[3] = key23_q[63:32];
	assign k[4] = key45_q[31:0];
	assign k[5] = key45_q[63:32];
	assign k[6] = key67_q[31:0];
	assign k[7] = key67_q[63:32];

	// Expansion by key size; code 3 acts as a 256-bit key.
	always_comb begin
		for (int i = 0; i < 8; i++) ek[i] = k[i];
		case (ksize_q)
			belt_pkg::KSIZE_128: begin
				for (int i = 0; i < 4; i++) ek[i + 4] = k[i];
			end
			belt_pkg::KSIZE_192: begin
				ek[6] = k[0] ^ k[1] ^ k[2];
				ek[7] = k[3] ^ k[4] ^ k[5];
			end
			default: ;
		endcase
	end

endmodule

/* rtl/belt_half_round.sv */
// ---------------------------------------------------------------------------
// Pipelined half round
// One pipeline stage doing either the first or the second half of a round.
// ---------------------------------------------------------------------------
module belt_half_round #(
	parameter int unsigned ROUND = 0,
	parameter bit          SECOND = 1'b0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  belt_pkg::blk_t  in_blk,
	input  belt_pkg::word_t ek [8],
	output logic            out_valid,
	output belt_pkg::blk_t  out_blk
);

	localparam int unsigned BASE = 7 * ROUND;
	localparam logic [31:0] RNUM = 32'(ROUND + 1);

	belt_pkg::blk_t nxt;
	belt_pkg::word_t a, b, c, d, e;
	logic vld_s1;
	belt_pkg::blk_t blk_s1;

	// First half: steps one to three; second half: the rest and the swaps.
	always_comb begin
		a = in_blk.a;
		b = in_blk.b;
		c = in_blk.c;
		d = in_blk.d;
		e = '0;
		if (!SECOND) begin
			b = b ^ belt_pkg::g_fn(a + ek[(BASE + 0) % 8], 5'd5);
			c = c ^ belt_pkg::g_fn(d + ek[(BASE + 1) % 8], 5'd21);
			a = a - belt_pkg::g_fn(b + ek[(BASE + 2) % 8], 5'd13);
			nxt = '{a: a, b: b, c: c, d: d};
		end else begin
			e = belt_pkg::g_fn(b + c + ek[(BASE + 3) % 8], 5'd21) ^ RNUM;
			b = b + e;
			c = c - e;
			d = d + belt_pkg::g_fn(c + ek[(BASE + 4) % 8], 5'd13);
			b = b ^ belt_pkg::g_fn(a + ek[(BASE + 5) % 8], 5'd21);
			c = c ^ belt_pkg::g_fn(d + ek[(BASE + 6) % 8], 5'd5);
			nxt = '{a: b, b: d, c: a, d: c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			blk_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_blk   = blk_s1;

endmodule

/* rtl/belt_block_encrypt_core.sv */
// ---------------------------------------------------------------------------
// BelT block encryption core
// Eight-round encryption of 128-bit blocks in an unrolled pipeline.
// ---------------------------------------------------------------------------
// The core takes one block per cycle while not stalled and returns it encrypted at
// the end of the pipe (two register stages per round, eight rounds); the whole pipe
// moves together and halts only when the output is stalled while holding a result,
// so it sustains one block per clock. The user writes the key through the configuration
// port only while the pipe is empty, which the core does not enforce; it is expanded combinationally.
module belt_block_encrypt_core #(
	parameter int unsigned ROUND_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] plain_word_0,
	input  logic [31:0] plain_word_1,
	input  logic [31:0] plain_word_2,
	input  logic [31:0] plain_word_3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] cipher_word_0,
	output logic [31:0] cipher_word_1,
	output logic [31:0] cipher_word_2,
	output logic [31:0] cipher_word_3
);

	localparam int unsigned STAGES = 2 * ROUND_COUNT;

	belt_pkg::word_t ek [8];
	logic            vld [STAGES + 1];
	belt_pkg::blk_t  blk [STAGES + 1];
	logic            adv;

	belt_keysched u_keys (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .ek(ek)
	);

	// The pipe advances unless the last stage holds a result that is stalled.
	assign adv      = !(vld[STAGES] && out_stall);
	assign in_stall = !adv;

	assign vld[0] = in_valid;
	assign blk[0] = '{a: plain_word_0, b: plain_word_1, c: plain_word_2, d: plain_word_3};

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		belt_half_round #(.ROUND(s / 2), .SECOND(s % 2 == 1)) u_half (
			.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(vld[s]), .in_blk(blk[s]),
			.ek(ek), .out_valid(vld[s + 1]), .out_blk(blk[s + 1])
		);
	end

	// The ciphertext is the final state read out in the order b, d, a, c.
	assign out_valid     = vld[STAGES];
	assign cipher_word_0 = blk[STAGES].b;
	assign cipher_word_1 = blk[STAGES].d;
	assign cipher_word_2 = blk[STAGES].a;
	assign cipher_word_3 = blk[STAGES].c;

`include "belt_block_encrypt_core_assert.svh"

	`BELT_ASSERT_IMP(a_stall_only_full, clk, arst_n, in_stall, out_valid && out_stall)
	`BELT_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && out_stall, out_valid)
	`BELT_ASSERT_NEXT(a_hold_data, clk, arst_n, out_valid && out_stall, $stable(cipher_word_0))

endmodule

/* verif/belt_block_encrypt_checker.sv */
// ---------------------------------------------------------------------------
// Block encryption checker
// Watches both channels of the encryption core, predicts each ciphertext
// block from the accepted plaintext and the current key, and compares.
// ---------------------------------------------------------------------------
module belt_block_encrypt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] plain_word_0,
	input  logic [31:0] plain_word_1,
	input  logic [31:0] plain_word_2,
	input  logic [31:0] plain_word_3,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] cipher_word_0,
	input  logic [31:0] cipher_word_1,
	input  logic [31:0] cipher_word_2,
	input  logic [31:0] cipher_word_3,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [127:0] cipher_blk_t;

	// Substitution table, kept locally so the prediction does not lean on the RTL.
	logic [7:0] h_box [256] = '{
		8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
		8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
		8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
		8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
		8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
		8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
		8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
		8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
		8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
		8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
		8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
		8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
		8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
		8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
		8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
		8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D};

	// Shadow copy of the key registers.
	logic [31:0] key_word [8];
	logic [1:0]  key_len;
	cipher_blk_t cipher_queue [$];

	// Byte substitution followed by a left rotation.
	function automatic belt_pkg::word_t subst_rotate(input belt_pkg::word_t x, input int r);
		belt_pkg::word_t y;
		y = {h_box[x[31:24]], h_box[x[23:16]], h_box[x[15:8]], h_box[x[7:0]]};
		return (y << r) | (y >> (32 - r));
	endfunction

	// Full eight-round encryption; returns words b, d, a, c packed low to high.
	function automatic cipher_blk_t encrypt_block(input belt_pkg::word_t pa,
			input belt_pkg::word_t pb, input belt_pkg::word_t pc, input belt_pkg::word_t pd);
		belt_pkg::word_t rk [8];
		belt_pkg::word_t a, b, c, d, e, t;
		a = pa; b = pb; c = pc; d = pd;
		// Round key schedule depends on the key length.
		for (int i = 0; i < 8; i++) begin
			if (key_len == belt_pkg::KSIZE_128)
				rk[i] = key_word[i % 4];
			else
				rk[i] = key_word[i];
		end
		if (key_len == belt_pkg::KSIZE_192) begin
			rk[6] = key_word[0] ^ key_word[1] ^ key_word[2];
			rk[7] = key_word[3] ^ key_word[4] ^ key_word[5];
		end
		for (int i = 0; i < 8; i++) begin
			b ^= subst_rotate(a + rk[(7*i) % 8], 5);
			c ^= subst_rotate(d + rk[(7*i + 1) % 8], 21);
			a -= subst_rotate(b + rk[(7*i + 2) % 8], 13);
			e = subst_rotate(b + c + rk[(7*i + 3) % 8], 21) ^ belt_pkg::word_t'(i + 1);
			b += e;
			c -= e;
			d += subst_rotate(c + rk[(7*i + 4) % 8], 13);
			b ^= subst_rotate(a + rk[(7*i + 5) % 8], 21);
			c ^= subst_rotate(d + rk[(7*i + 6) % 8], 5);
			t = a; a = b; b = t;
			t = c; c = d; d = t;
			t = b; b = c; c = t;
		end
		return {c, a, d, b};
	endfunction

	task automatic report_mismatch(input string what, input belt_pkg::word_t got,
			input belt_pkg::word_t want);
		$display("mismatch at %0t: %s got %08h expected %08h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Track key writes, predict on each input transfer, check each output transfer.
	always @(posedge clk or negedge arst_n) begin
		cipher_blk_t want;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) key_word[i] = '0;
			key_len = 2'd2;
			cipher_queue.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					belt_pkg::REG_KEY_01: {key_word[1], key_word[0]} = cfg_data;
					belt_pkg::REG_KEY_23: {key_word[3], key_word[2]} = cfg_data;
					belt_pkg::REG_KEY_45: {key_word[5], key_word[4]} = cfg_data;
					belt_pkg::REG_KEY_67: {key_word[7], key_word[6]} = cfg_data;
					belt_pkg::REG_KEY_SIZE: key_len = cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				cipher_queue.push_back(encrypt_block(plain_word_0, plain_word_1,
					plain_word_2, plain_word_3));
			if (out_valid && !out_stall) begin
				if (cipher_queue.size() == 0) begin
					$display("unexpected output transfer at %0t", $realtime);
					fail_count++;
				end else begin
					want = cipher_queue.pop_front();
					if (cipher_word_0 !== want[31:0])
						report_mismatch("cipher_word_0", cipher_word_0, want[31:0]);
					if (cipher_word_1 !== want[63:32])
						report_mismatch("cipher_word_1", cipher_word_1, want[63:32]);
					if (cipher_word_2 !== want[95:64])
						report_mismatch("cipher_word_2", cipher_word_2, want[95:64]);
					if (cipher_word_3 !== want[127:96])
						report_mismatch("cipher_word_3", cipher_word_3, want[127:96]);
				end
			end
			pending_count = cipher_queue.size();
		end
	end

endmodule

/* verif/testbench.sv */
// ---------------------------------------------------------------------------
// Block encryption core testbench
// Drives key settings and plaintext blocks under varied idling and stalls;
// the checker predicts and compares every ciphertext block.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 5000;
	localparam logic [2:0] REG_NONE = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] plain_word_0 = '0, plain_word_1 = '0, plain_word_2 = '0, plain_word_3 = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] cipher_word_0, cipher_word_1, cipher_word_2, cipher_word_3;
	int          fail_count;
	int          pending_count;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	belt_block_encrypt_core dut (.*);

	belt_block_encrypt_checker checker_inst (.*);

	// Receiver stalls at random at the current rate.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits for the pipe to empty before the key changes.
	task automatic drain();
		int n;
		n = 0;
		while (pending_count != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Stall is steady between edges, so it is sampled at the falling edge
	// before the rising edge that takes the transfer.
	task automatic send_block(input logic [31:0] w0, w1, w2, w3);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		plain_word_0 <= w0;
		plain_word_1 <= w1;
		plain_word_2 <= w2;
		plain_word_3 <= w3;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_block($urandom, $urandom, $urandom, $urandom);
		in_valid <= 1'b0;
	endtask

	task automatic load_key(input logic [1:0] size_code);
		write_reg(belt_pkg::REG_KEY_01, {$urandom, $urandom});
		write_reg(belt_pkg::REG_KEY_23, {$urandom, $urandom});
		write_reg(belt_pkg::REG_KEY_45, {$urandom, $urandom});
		write_reg(belt_pkg::REG_KEY_67, {$urandom, $urandom});
		write_reg(belt_pkg::REG_KEY_SIZE, {$urandom, 30'h0, size_code});
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset key: all-zero 256-bit key, with extreme blocks.
		send_block('0, '0, '0, '0);
		send_block('1, '1, '1, '1);
		send_block(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
		in_valid <= 1'b0;
		drain();

		// All-ones 128-bit key; unused words and an out-of-range index are ignored.
		write_reg(belt_pkg::REG_KEY_01, '1);
		write_reg(belt_pkg::REG_KEY_23, '1);
		write_reg(belt_pkg::REG_KEY_45, 64'h5555_AAAA_5555_AAAA);
		write_reg(belt_pkg::REG_KEY_67, 64'hAAAA_5555_AAAA_5555);
		write_reg(belt_pkg::REG_KEY_SIZE, {62'h0, belt_pkg::KSIZE_128});
		write_reg(REG_NONE, '1);
		send_block('0, '0, '0, '0);
		send_block('1, '1, '1, '1);
		send_block(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
		in_valid <= 1'b0;
		drain();

		// 192-bit key; words 6 and 7 ignored.
		write_reg(belt_pkg::REG_KEY_SIZE, {62'h0, belt_pkg::KSIZE_192});
		send_block('0, '1, '0, '1);
		send_block('1, '0, '1, '0);
		in_valid <= 1'b0;
		drain();

		// Key size code 3 acts as 256-bit; upper data bits masked.
		write_reg(belt_pkg::REG_KEY_SIZE, '1);
		send_block('0, '0, '0, '0);
		send_block('1, '1, '1, '1);
		in_valid <= 1'b0;
		drain();

		// Random phases over each key size and idling mix.
		for (int phase = 0; phase < 16; phase++) begin
			load_key(2'(phase % 4));
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			send_random(31);
			drain();
		end

		recv_stall_pct = 0;
		drain();
		if (fail_count == 0 && pending_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
